// ===== src/cpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_pkg
// Types and codes shared by the clock page replacement core and its testbench.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int unsigned FRAME_W = 8;
  localparam int unsigned TABLE_W = 8;
  localparam int unsigned PAGE_W  = 10;
  localparam int unsigned FPP_W   = 7;
  localparam int unsigned CIDX_W  = 8;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_FAULT  = 1'b1;

  localparam logic MODE_PLAIN    = 1'b0;
  localparam logic MODE_ENHANCED = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_MODE = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_FPP  = 8'd1;

  localparam logic             MODE_RESET = MODE_ENHANCED;
  localparam logic [FPP_W-1:0] FPP_RESET  = 7'd4;

  typedef struct packed {
    logic               opcode;
    logic [TABLE_W-1:0] table_id;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame;
    logic               write_flag;
    logic               memory_full;
  } cpr_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] assigned_frame;
    logic               replaced;
    logic [TABLE_W-1:0] victim_table;
    logic [PAGE_W-1:0]  victim_page;
    logic               writeback_needed;
    logic               error;
  } cpr_out_t;

  // one resident queue slot
  typedef struct packed {
    logic [TABLE_W-1:0] table_id;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame;
  } cpr_slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_QRD,
    S_BRD,
    S_EVAL
  } cpr_state_t;

endpackage

// ===== src/cpr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/clock_page_replacement_core.sv =====
`timescale 1ns / 1ps
// Access, append and empty-queue items finish in dispatch and strobe out_valid
//   as busy drops; busy is high for one cycle. A replacement adds queue read, bit read and
//   evaluate states per slot examined (plain: at most count+1, enhanced: at most 3*count+1).
// Throughput: one item at a time; start is taken the cycle busy drops.
// Reset: after rst_n releases, the used/modified RAMs are swept, every frame address
//   cleared, with busy high. Results are strobed, never held: the receiver cannot stall.
// ----------------------------------------------------------------------------
// clock_page_replacement_core
// Resident page queue with plain or enhanced second-chance clock replacement.
// ----------------------------------------------------------------------------
module clock_page_replacement_core #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned FRAME_COUNT = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // command channel
  input  logic                    start,
  output logic                    busy,
  input  cpr_pkg::cpr_in_t        in_data,
  // result channel, one-cycle strobe
  output logic                    out_valid,
  output cpr_pkg::cpr_out_t       out_data,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [cpr_pkg::CIDX_W-1:0] cfg_index,
  input  logic [cpr_pkg::FPP_W-1:0]  cfg_data
);

  import cpr_pkg::*;

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FAW = $clog2(FRAME_COUNT);
  localparam int unsigned SLOT_W = $bits(cpr_slot_t);
  localparam logic [QAW:0]   DEPTH_W   = (QAW+1)'(QUEUE_DEPTH);
  localparam logic [QAW-1:0] HEAD_LAST = QAW'(QUEUE_DEPTH - 1);
  localparam logic [FAW-1:0] CLR_LAST  = FAW'(FRAME_COUNT - 1);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  cpr_state_t       state_r, state_nxt;
  logic             mode_r, mode_nxt;
  logic [FPP_W-1:0] fpp_r, fpp_nxt;
  logic [QAW-1:0]   head_r, head_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic [QAW:0]     step_r, step_nxt;     // slots looked at in this pass
  logic             pass_r, pass_nxt;     // enhanced: 0 seeks (0,0), 1 seeks (0,1)
  logic [FAW-1:0]   clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  cpr_in_t          in_r, in_nxt;
  cpr_slot_t        ent_r, ent_nxt;       // slot at the clock hand
  logic             inrng_r, inrng_nxt;   // its frame has bits in the RAMs
  cpr_out_t         out_r, out_nxt;

  // RAM ports
  logic             q_we;
  logic [QAW-1:0]   q_waddr, q_raddr;
  cpr_slot_t        q_wdata;
  logic [SLOT_W-1:0] q_rdata;
  logic             u_we, m_we, u_wdata, m_wdata;
  logic [FAW-1:0]   b_waddr, b_raddr;
  logic             u_rdata, m_rdata;

  cpr_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  cpr_ram #(.WIDTH(1), .DEPTH(FRAME_COUNT)) u_used (
    .clk, .we(u_we), .waddr(b_waddr), .wdata(u_wdata),
    .raddr(b_raddr), .rdata(u_rdata)
  );

  cpr_ram #(.WIDTH(1), .DEPTH(FRAME_COUNT)) u_mod (
    .clk, .we(m_we), .waddr(b_waddr), .wdata(m_wdata),
    .raddr(b_raddr), .rdata(m_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared decode
  // --------------------------------------------------------------------------
  cpr_slot_t          q_slot;
  logic [QAW:0]       tail_sum;
  logic [QAW-1:0]     tail;
  logic [QAW-1:0]     head_inc;
  logic [QAW:0]       step_inc;
  logic               pass_end;
  logic               accept;
  logic               lim_hit, do_append, q_empty;
  logic               u_eff, m_eff, victim_hit, clear_used;
  logic [FRAME_W+FAW-1:0] in_fext, q_fext, e_fext;
  logic               in_frng, q_frng;

  assign q_slot   = cpr_slot_t'(q_rdata);
  assign accept   = start && !busy;

  // tail = (head + count) mod depth; the sum stays below twice the depth
  assign tail_sum = {1'b0, head_r} + count_r;
  assign tail     = (tail_sum >= DEPTH_W) ? QAW'(tail_sum - DEPTH_W) : tail_sum[QAW-1:0];
  assign head_inc = (head_r == HEAD_LAST) ? '0 : head_r + QAW'(1);
  assign step_inc = step_r + (QAW+1)'(1);
  assign pass_end = (step_inc == count_r);

  // limit is frames_per_process capped at the queue depth
  assign lim_hit   = (32'(count_r) >= 32'(fpp_r)) || (count_r >= DEPTH_W);
  assign do_append = !in_r.memory_full && !lim_hit;
  assign q_empty   = (count_r == '0);

  // frame number to bit-RAM address; frames past FRAME_COUNT have no bits
  assign in_fext = {{FAW{1'b0}}, in_r.frame};
  assign q_fext  = {{FAW{1'b0}}, q_slot.frame};
  assign e_fext  = {{FAW{1'b0}}, ent_r.frame};
  assign in_frng = (32'(in_r.frame) < FRAME_COUNT);
  assign q_frng  = (32'(q_slot.frame) < FRAME_COUNT);

  assign u_eff = u_rdata && inrng_r;
  assign m_eff = m_rdata && inrng_r;

  always_comb begin
    if (mode_r == MODE_PLAIN) begin
      victim_hit = !u_eff;
    end else if (pass_r) begin
      victim_hit = !u_eff && m_eff;
    end else begin
      victim_hit = !u_eff && !m_eff;
    end
  end

  // plain clock and enhanced second pass take the second chance away
  assign clear_used = !victim_hit && ((mode_r == MODE_PLAIN) || pass_r);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (in_r.opcode == OP_FAULT && !do_append && !q_empty) begin
          state_nxt = S_QRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_QRD:  state_nxt = S_BRD;
      S_BRD:  state_nxt = S_EVAL;
      S_EVAL: state_nxt = victim_hit ? S_IDLE : S_QRD;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and RAM control
  // --------------------------------------------------------------------------
  always_comb begin
    mode_nxt      = mode_r;
    fpp_nxt       = fpp_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    pass_nxt      = pass_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    in_nxt        = in_r;
    ent_nxt       = ent_r;
    inrng_nxt     = inrng_r;
    out_nxt       = out_r;

    q_we    = 1'b0;
    q_waddr = tail;
    q_wdata = ent_r;
    q_raddr = head_r;
    u_we    = 1'b0;
    m_we    = 1'b0;
    u_wdata = 1'b0;
    m_wdata = 1'b0;
    b_waddr = e_fext[FAW-1:0];
    b_raddr = q_fext[FAW-1:0];

    // config beats are taken only while idle
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MODE) mode_nxt = cfg_data[0];
      if (cfg_index == CFG_FPP)  fpp_nxt  = cfg_data;
    end

    if (accept) in_nxt = in_data;

    unique case (state_r)
      S_CLEAR: begin
        u_we    = 1'b1;
        m_we    = 1'b1;
        b_waddr = clr_r;
        clr_nxt = clr_r + FAW'(1);
      end
      S_IDLE: begin
      end
      S_DISPATCH: begin
        out_nxt = '0;
        b_waddr = in_fext[FAW-1:0];
        if (in_r.opcode == OP_ACCESS) begin
          u_we          = in_frng;
          u_wdata       = 1'b1;
          m_we          = in_frng && in_r.write_flag;
          m_wdata       = 1'b1;
          out_valid_nxt = 1'b1;
        end else if (do_append) begin
          q_we    = 1'b1;
          q_wdata = '{table_id: in_r.table_id, page_number: in_r.page_number,
                      frame: in_r.frame};
          count_nxt = count_r + (QAW+1)'(1);
          u_we    = in_frng;
          m_we    = in_frng;
          out_nxt.assigned_frame = in_r.frame;
          out_valid_nxt = 1'b1;
        end else if (q_empty) begin
          out_nxt.error = 1'b1;
          out_valid_nxt = 1'b1;
        end else begin
          step_nxt = '0;
          pass_nxt = 1'b0;
        end
      end
      S_QRD: begin
        q_raddr = head_r;
      end
      S_BRD: begin
        // slot at the hand is on the queue read port; fetch its bits
        ent_nxt   = q_slot;
        inrng_nxt = q_frng;
        b_raddr   = q_fext[FAW-1:0];
      end
      S_EVAL: begin
        // pop at the hand, push at the tail; count stays put
        q_we     = 1'b1;
        head_nxt = head_inc;
        b_waddr  = e_fext[FAW-1:0];
        if (victim_hit) begin
          q_wdata = '{table_id: in_r.table_id, page_number: in_r.page_number,
                      frame: ent_r.frame};
          u_we    = inrng_r;
          m_we    = inrng_r;
          out_nxt.assigned_frame   = ent_r.frame;
          out_nxt.replaced         = 1'b1;
          out_nxt.victim_table     = ent_r.table_id;
          out_nxt.victim_page      = ent_r.page_number;
          out_nxt.writeback_needed = m_eff;
          out_valid_nxt = 1'b1;
        end else begin
          q_wdata = ent_r;
          u_we    = inrng_r && clear_used;
          if (pass_end) begin
            step_nxt = '0;
            pass_nxt = !pass_r;
          end else begin
            step_nxt = step_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      mode_r      <= MODE_RESET;
      fpp_r       <= FPP_RESET;
      head_r      <= '0;
      count_r     <= '0;
      step_r      <= '0;
      pass_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      fpp_r       <= fpp_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      pass_r      <= pass_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    ent_r   <= ent_nxt;
    inrng_r <= inrng_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_W) else $error("queue count past depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(head_r) < QUEUE_DEPTH) else $error("clock hand out of range");

  a_eval_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> count_r != '0) else $error("victim search on empty queue");

  a_search_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |=> $stable(count_r)) else $error("count moved during search");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DISPATCH || state_r == S_EVAL))
    else $error("result strobe without finished item");

endmodule

// ===== tb/sv/tb_clock_page_replacement_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_page_replacement_core
// Self-checking bench for the clock page replacement core. A command queue
// (page accesses, page faults, register writes) is built up front: first a
// directed run, then random phases under varied clock modes and page limits.
// A clocked driver feeds it with random gaps. A clocked monitor checks each
// strobed result against an in-bench model of the resident queue and the
// used/dirty bits.
// ----------------------------------------------------------------------------
module tb_clock_page_replacement_core;
  import cpr_pkg::*;

  localparam int QDEPTH       = 64;      // resident queue slots in the core
  localparam int FCOUNT       = 256;     // physical frames tracked
  localparam int QUIET_CYCLES = 4;       // idle cycles before a register write
  localparam int CYCLE_LIMIT  = 5000000;
  localparam int RUN_LEN      = 150;     // random beats per phase
  localparam int NUM_PHASES   = 12;
  localparam int CALM_FROM    = 900;     // first beat of a stretch sent without any gap
  localparam int CALM_TO      = 1150;
  // register index that decodes to nothing; writes must be ignored
  localparam logic [CIDX_W-1:0] CFG_SPARE = 8'd2;

  // one entry of the command backlog: a register write or an input beat
  typedef struct packed {
    logic               is_cfg;
    logic [CIDX_W-1:0]  reg_idx;
    logic [FPP_W-1:0]   reg_val;
    cpr_in_t            item;
  } cmd_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  cpr_in_t             in_data   = '0;
  logic                out_valid;
  cpr_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [FPP_W-1:0]    cfg_data  = '0;

  clock_page_replacement_core #(
    .QUEUE_DEPTH (QDEPTH),
    .FRAME_COUNT (FCOUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  cmd_t      cmd_backlog[$];     // commands not yet presented
  cpr_out_t  placements_due[$];  // predicted results, oldest first
  int        fail_count  = 0;
  int        cycle_count = 0;
  int        in_flight   = 0;    // accepted beats still owed a result
  int        quiet       = 0;    // consecutive cycles with the core at rest
  int        sent        = 0;    // input beats presented so far

  // Model of the core: resident queue (clock hand = head) plus per-frame bits
  cpr_slot_t    res_slot [QDEPTH];
  int           res_head;
  int           res_count;
  logic         used_bit  [FCOUNT];
  logic         dirty_bit [FCOUNT];
  logic         clock_mode;
  logic [FPP_W-1:0] page_limit;

  // Per-phase settings for the random part; both extremes of each register,
  // a zero limit (always replace) and limits above the queue depth (capped).
  logic phase_mode [NUM_PHASES] = '{MODE_PLAIN, MODE_ENHANCED, MODE_PLAIN,
                                    MODE_ENHANCED, MODE_ENHANCED, MODE_PLAIN,
                                    MODE_ENHANCED, MODE_PLAIN, MODE_ENHANCED,
                                    MODE_PLAIN, MODE_ENHANCED, MODE_PLAIN};
  int   phase_fpp  [NUM_PHASES] = '{4, 1, 64, 64, 127, 0, 8, 2, 100, 16, 3, 1};

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the resident queue
  // --------------------------------------------------------------------------
  function automatic void slot_push(cpr_slot_t s);
    res_slot[(res_head + res_count) % QDEPTH] = s;
    res_count++;
  endfunction

  function automatic cpr_slot_t slot_pop();
    cpr_slot_t s;
    s = res_slot[res_head];
    res_head = (res_head + 1) % QDEPTH;
    res_count--;
    return s;
  endfunction

  // Sweep the clock hand until a victim turns up. The count stays fixed during
  // a sweep since every pass-over goes back on the tail.
  function automatic cpr_slot_t pick_clock_victim();
    cpr_slot_t s;
    int        n;
    bit        hit;
    s   = '0;
    n   = res_count;
    hit = 1'b0;
    if (clock_mode == MODE_PLAIN) begin
      // second chance: a used page loses its bit and goes round again
      for (int i = 0; i <= n && !hit; i++) begin
        s = slot_pop();
        if (!used_bit[s.frame]) begin
          hit = 1'b1;
        end else begin
          used_bit[s.frame] = 1'b0;
          slot_push(s);
        end
      end
    end else begin
      // even pass: clean and unused; odd pass: dirty and unused, clearing
      // used bits on the way. Two pairs of passes always find one.
      for (int p = 0; p < 4 && !hit; p++) begin
        for (int i = 0; i < n && !hit; i++) begin
          s = slot_pop();
          if (!used_bit[s.frame] && (dirty_bit[s.frame] == p[0])) begin
            hit = 1'b1;
          end else begin
            if (p[0]) used_bit[s.frame] = 1'b0;
            slot_push(s);
          end
        end
      end
    end
    return s;
  endfunction

  // Expected result of one accepted beat; updates the model state.
  function automatic cpr_out_t predict_placement(cpr_in_t it);
    cpr_out_t  r;
    cpr_slot_t s;
    cpr_slot_t v;
    int        lim;
    r = '0;
    if (it.opcode == OP_ACCESS) begin
      used_bit[it.frame] = 1'b1;
      if (it.write_flag) dirty_bit[it.frame] = 1'b1;
      return r;
    end
    lim           = (page_limit > QDEPTH) ? QDEPTH : int'(page_limit);
    s.table_id    = it.table_id;
    s.page_number = it.page_number;
    // free frame on offer and room left: plain append
    if (!it.memory_full && res_count < lim) begin
      s.frame             = it.frame;
      used_bit[it.frame]  = 1'b0;
      dirty_bit[it.frame] = 1'b0;
      slot_push(s);
      r.assigned_frame = it.frame;
      return r;
    end
    // nothing to evict
    if (res_count == 0) begin
      r.error = 1'b1;
      return r;
    end
    v = pick_clock_victim();
    r.assigned_frame    = v.frame;
    r.replaced          = 1'b1;
    r.victim_table      = v.table_id;
    r.victim_page       = v.page_number;
    r.writeback_needed  = dirty_bit[v.frame];
    used_bit[v.frame]   = 1'b0;
    dirty_bit[v.frame]  = 1'b0;
    s.frame             = v.frame;
    slot_push(s);
    return r;
  endfunction

  function automatic void write_register(logic [CIDX_W-1:0] idx, logic [FPP_W-1:0] val);
    case (idx)
      CFG_MODE: clock_mode = val[0];
      CFG_FPP:  page_limit = val;
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Command backlog builders
  // --------------------------------------------------------------------------
  task automatic queue_beat(logic op, logic [7:0] tbl, logic [9:0] pg, logic [7:0] fr,
                            logic wr, logic full);
    cmd_t c;
    c                  = '0;
    c.item.opcode      = op;
    c.item.table_id    = tbl;
    c.item.page_number = pg;
    c.item.frame       = fr;
    c.item.write_flag  = wr;
    c.item.memory_full = full;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_write(logic [CIDX_W-1:0] idx, logic [FPP_W-1:0] val);
    cmd_t c;
    c         = '0;
    c.is_cfg  = 1'b1;
    c.reg_idx = idx;
    c.reg_val = val;
    cmd_backlog.push_back(c);
  endtask

  // Mode write with junk in the upper data bits; only bit 0 counts.
  task automatic queue_mode(logic mode);
    queue_write(CFG_MODE, {6'($urandom_range(0, 63)), mode});
  endtask

  // Random beats. Frames mostly come from a random window a little wider than the page
  // limit, so accesses land on resident frames and the used/dirty bits matter.
  task automatic queue_random_run(int n_beats, int pool);
    logic [7:0] base;
    logic [7:0] fr;
    base = 8'($urandom_range(0, 255));
    repeat (n_beats) begin
      if ($urandom_range(0, 99) < 85) fr = 8'(base + $urandom_range(0, pool - 1));
      else                            fr = 8'($urandom_range(0, 255));
      queue_beat(($urandom_range(0, 99) < 40) ? OP_FAULT : OP_ACCESS,
                 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)), fr,
                 1'($urandom_range(0, 1)), ($urandom_range(0, 99) < 25));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int lim;
    res_head   = 0;
    res_count  = 0;
    clock_mode = MODE_RESET;
    page_limit = FPP_RESET;
    for (int f = 0; f < FCOUNT; f++) begin
      used_bit[f]  = 1'b0;
      dirty_bit[f] = 1'b0;
    end

    // Directed run under the reset settings (enhanced, four pages)
    queue_write(CFG_MODE, 7'(MODE_ENHANCED));
    queue_write(CFG_FPP, 7'd4);
    queue_beat(OP_FAULT, 8'h00, 10'h000, 8'h00, 1'b0, 1'b1);   // fault on empty queue
    queue_beat(OP_ACCESS, 8'h00, 10'h000, 8'h00, 1'b0, 1'b0);  // access: all-zero result
    queue_beat(OP_ACCESS, 8'hFF, 10'h3FF, 8'hFF, 1'b1, 1'b1);
    queue_beat(OP_FAULT, 8'h00, 10'h000, 8'h00, 1'b0, 1'b0);   // appends fill to limit
    queue_beat(OP_FAULT, 8'hFF, 10'h3FF, 8'hFF, 1'b1, 1'b0);
    queue_beat(OP_FAULT, 8'h5A, 10'h2A5, 8'h80, 1'b0, 1'b0);
    queue_beat(OP_FAULT, 8'hA5, 10'h15A, 8'h7F, 1'b1, 1'b0);
    queue_beat(OP_ACCESS, 8'h00, 10'h000, 8'h00, 1'b1, 1'b0);
    queue_beat(OP_ACCESS, 8'h00, 10'h000, 8'hFF, 1'b0, 1'b0);
    queue_beat(OP_ACCESS, 8'h00, 10'h000, 8'h80, 1'b1, 1'b0);
    queue_beat(OP_FAULT, 8'h11, 10'h111, 8'h40, 1'b0, 1'b0);   // at limit: clean victim
    queue_beat(OP_FAULT, 8'h22, 10'h222, 8'h41, 1'b0, 1'b1);   // memory full
    queue_beat(OP_ACCESS, 8'h00, 10'h000, 8'h7F, 1'b1, 1'b0);
    queue_beat(OP_ACCESS, 8'h00, 10'h000, 8'h80, 1'b1, 1'b0);
    queue_beat(OP_FAULT, 8'h33, 10'h333, 8'h42, 1'b0, 1'b1);   // all used: second pair
    // plain clock, limit lowered under the current count
    queue_mode(MODE_PLAIN);
    queue_write(CFG_FPP, 7'd1);
    queue_beat(OP_FAULT, 8'h44, 10'h044, 8'h43, 1'b0, 1'b0);
    queue_beat(OP_ACCESS, 8'h00, 10'h000, 8'h00, 1'b0, 1'b0);
    queue_beat(OP_FAULT, 8'h55, 10'h155, 8'h44, 1'b1, 1'b0);
    // zero limit always replaces; spare index is a no-op
    queue_write(CFG_FPP, 7'd0);
    queue_write(CFG_SPARE, 7'h7F);
    queue_beat(OP_FAULT, 8'h66, 10'h266, 8'h45, 1'b0, 1'b0);
    // largest limit, capped at queue depth: appends resume
    queue_mode(MODE_ENHANCED);
    queue_write(CFG_FPP, 7'h7F);
    queue_beat(OP_FAULT, 8'h77, 10'h377, 8'h01, 1'b0, 1'b0);
    queue_beat(OP_FAULT, 8'h88, 10'h088, 8'hFE, 1'b1, 1'b0);
    queue_beat(OP_FAULT, 8'h99, 10'h199, 8'h02, 1'b0, 1'b0);

    // Random phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      queue_mode(phase_mode[ph]);
      queue_write(CFG_FPP, 7'(phase_fpp[ph]));
      lim = (phase_fpp[ph] > QDEPTH) ? QDEPTH : phase_fpp[ph];
      queue_random_run(RUN_LEN, lim + 4);
    end

    // Reset held low from time zero, released once
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Settle checks on the falling edge so the driver's updates are in
    while (cmd_backlog.size() != 0 || start || cfg_valid) @(negedge clk);
    while (placements_due.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && placements_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: one beat or one register write at a time. A beat counts as taken
  // at the edge where start is high and busy is low; it is predicted there.
  // Register writes wait until the core is at rest with nothing owed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic nxt_start;
    logic nxt_cfg;
    cmd_t nxt;
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid;
      if (start && !busy) begin
        placements_due.push_back(predict_placement(in_data));
        in_flight++;
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        write_register(cfg_index, cfg_data);
        nxt_cfg = 1'b0;
      end
      if (out_valid && in_flight > 0) in_flight--;
      quiet = (busy || out_valid || start || in_flight != 0) ? 0 : quiet + 1;

      if (!nxt_start && !nxt_cfg && cmd_backlog.size() != 0) begin
        if (cmd_backlog[0].is_cfg) begin
          if (in_flight == 0 && quiet >= QUIET_CYCLES) begin
            nxt       = cmd_backlog.pop_front();
            cfg_index <= nxt.reg_idx;
            cfg_data  <= nxt.reg_val;
            nxt_cfg   = 1'b1;
          end
        end else if ((sent >= CALM_FROM && sent < CALM_TO) ||
                     $urandom_range(0, 99) >= 30) begin
          // ~30% gaps, except a stretch of back-to-back beats
          nxt     = cmd_backlog.pop_front();
          in_data <= nxt.item;
          nxt_start = 1'b1;
          sent++;
        end
      end
      // single assignment per edge keeps start high across back-to-back beats
      start     <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobe must match the oldest prediction, field by field
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    cpr_out_t want;
    if (rst_n && out_valid) begin
      if (placements_due.size() == 0) begin
        $error("result strobe with nothing outstanding: %h", out_data);
        fail_count++;
      end else begin
        want = placements_due.pop_front();
        check_field("assigned_frame", 32'(want.assigned_frame),
                    32'(out_data.assigned_frame));
        check_field("replaced", 32'(want.replaced), 32'(out_data.replaced));
        check_field("victim_table", 32'(want.victim_table), 32'(out_data.victim_table));
        check_field("victim_page", 32'(want.victim_page), 32'(out_data.victim_page));
        check_field("writeback_needed", 32'(want.writeback_needed),
                    32'(out_data.writeback_needed));
        check_field("error", 32'(want.error), 32'(out_data.error));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
src/cpr_pkg.sv
src/cpr_ram.sv
src/clock_page_replacement_core.sv
tb/sv/tb_clock_page_replacement_core.sv
